/* rtl/mapping_window_slot_allocator_defines.svh */
// Assertion macros shared by the RTL of the slot allocator.
// Each macro takes a label, a condition, a consequence and a message.
`ifndef MAPPING_WINDOW_SLOT_ALLOCATOR_DEFINES_SVH
`define MAPPING_WINDOW_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define MWSA_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MWSA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MWSA_ASSERT_IMP(name, ante, cons, msg)
`define MWSA_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

/* rtl/mwsa_pkg.sv */
`default_nettype none
package mwsa_pkg;

	localparam int DEF_NUM_SLOTS = 32;
	// Page size must be a power of two; slot indexing is a shift.
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	localparam int ADDR_W   = 32;
	localparam int PAGE_W   = 32;
	localparam int OFFSET_W = 12;
	localparam int OP_W     = 2;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [PAGE_W-1:0]   page_t;
	typedef logic [OFFSET_W-1:0] offset_t;

	localparam op_t OP_ALLOC = 2'd0;
	localparam op_t OP_FLUSH = 2'd1;
	localparam op_t OP_FREE  = 2'd2;

	localparam kind_t KIND_ALLOC = 2'd0;
	localparam kind_t KIND_MAP   = 2'd1;
	localparam kind_t KIND_DONE  = 2'd2;
	localparam kind_t KIND_FREE  = 2'd3;

	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_FULL_WAIT  = 3'd1;
	localparam status_t ST_FULL_FATAL = 3'd2;
	localparam status_t ST_NOT_IN_USE = 3'd3;
	localparam status_t ST_OUT_RANGE  = 3'd4;

	typedef logic alu_op_t;
	localparam alu_op_t ALU_ADD = 1'b0;
	localparam alu_op_t ALU_SUB = 1'b1;

endpackage
`default_nettype wire

/* rtl/mwsa_if.sv */
`default_nettype none
interface mwsa_req_if;
	logic                  valid;
	logic                  ready;
	mwsa_pkg::op_t         operation;
	mwsa_pkg::page_t       page_handle;
	mwsa_pkg::offset_t     page_offset;
	logic                  may_wait;
	mwsa_pkg::addr_t       free_address;

	modport source (output valid, operation, page_handle, page_offset, may_wait,
		free_address, input ready);
	modport sink (input valid, operation, page_handle, page_offset, may_wait,
		free_address, output ready);
endinterface

interface mwsa_rsp_if;
	logic                  valid;
	logic                  ready;
	mwsa_pkg::kind_t       kind;
	mwsa_pkg::status_t     status;
	mwsa_pkg::addr_t       slot_address;
	mwsa_pkg::page_t       mapped_page;
	logic                  wake_waiters;
	logic                  last;

	modport source (output valid, kind, status, slot_address, mapped_page,
		wake_waiters, last, input ready);
	modport sink (input valid, kind, status, slot_address, mapped_page,
		wake_waiters, last, output ready);
endinterface

interface mwsa_cfg_if;
	logic                  valid;
	logic                  ready;
	mwsa_pkg::addr_t       window_base;

	modport source (output valid, window_base, input ready);
	modport sink (input valid, window_base, output ready);
endinterface
`default_nettype wire

/* rtl/mwsa_ram.sv */
`default_nettype none
module mwsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [WIDTH-1:0]      wdata,
	input  wire logic                  re,
	input  wire logic [AW-1:0]         raddr,
	output logic      [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* rtl/mwsa_alu.sv */
`default_nettype none
module mwsa_alu (
	input  wire mwsa_pkg::alu_op_t op,
	input  wire mwsa_pkg::addr_t   a,
	input  wire mwsa_pkg::addr_t   b,
	output mwsa_pkg::addr_t        sum
);
	// One adder serves slot addresses, offsets and the free-address difference.
	always_comb begin
		case (op)
			mwsa_pkg::ALU_SUB: sum = a - b;
			default:           sum = a + b;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/mapping_window_slot_allocator.sv */
// First-fit allocator for a window of page-sized address slots.
// Channels: req (operation, page_handle, page_offset, may_wait, free_address)
// with valid/ready, rsp (kind, status, slot_address, mapped_page,
// wake_waiters, last) with valid/ready, and cfg, which writes window_base
// whenever cfg.valid is high; cfg is always ready.
// One request is worked at a time; req.ready is high only while idle.
// An allocate passes through S_ALLOC and then S_ALLOC2, a free through S_FREE
// and then S_FREE2, before its result is loaded into the output register,
// and the next request is taken only once that result is loaded and the
// sequencer is back in idle; an allocate into a full window answers from
// S_ALLOC. The shared adder is used twice for an allocate, once for a free.
// A flush walks every slot in S_FLCHK, with a further step in S_FLEMIT for
// each pending slot, whose page is read from the page store, and then loads
// the done marker; the flush returns pending + 1 results.
// Results pass through a single output register; while the receiver stalls
// the sequencer waits and no state changes for the held result.
// Reset marks every slot free, sets the free count to NUM_SLOTS and clears
// window_base; the page store needs no clearing because a page is only read
// back for a slot that was allocated since.
`default_nettype none
`include "mapping_window_slot_allocator_defines.svh"
module mapping_window_slot_allocator #(
	parameter int NUM_SLOTS = mwsa_pkg::DEF_NUM_SLOTS
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mwsa_cfg_if.sink    cfg,
	mwsa_req_if.sink    req,
	mwsa_rsp_if.source  rsp
);
	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int HW = mwsa_pkg::ADDR_W - mwsa_pkg::PAGE_SHIFT;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ALLOC  = 3'd1;
	localparam logic [2:0] S_ALLOC2 = 3'd2;
	localparam logic [2:0] S_FLCHK  = 3'd3;
	localparam logic [2:0] S_FLEMIT = 3'd4;
	localparam logic [2:0] S_FREE   = 3'd5;
	localparam logic [2:0] S_FREE2  = 3'd6;

	logic [2:0]             state_q;
	mwsa_pkg::addr_t        base_q;
	logic [NUM_SLOTS-1:0]   pending_q;
	logic [NUM_SLOTS-1:0]   used_q;
	logic [CW-1:0]          free_cnt_q;
	logic [CW-1:0]          scan_q;
	mwsa_pkg::addr_t        acc_q;
	mwsa_pkg::page_t        page_q;
	mwsa_pkg::offset_t      offset_q;
	logic                   wait_q;
	mwsa_pkg::addr_t        faddr_q;

	logic                   rsp_valid_q;
	mwsa_pkg::kind_t        kind_q;
	mwsa_pkg::status_t      status_q;
	mwsa_pkg::addr_t        addr_q;
	mwsa_pkg::page_t        mpage_q;
	logic                   wake_q;
	logic                   last_q;

	logic [NUM_SLOTS-1:0]   free_vec;
	logic [IW-1:0]          ff_idx;
	logic [IW-1:0]          scan_idx;
	logic [IW-1:0]          fidx;
	logic                   scan_end;
	logic                   oor;
	logic                   out_free;
	logic                   req_known_op;

	mwsa_pkg::alu_op_t      alu_op;
	mwsa_pkg::addr_t        alu_a;
	mwsa_pkg::addr_t        alu_b;
	mwsa_pkg::addr_t        alu_sum;

	logic                   ram_we;
	logic                   ram_re;
	mwsa_pkg::page_t        ram_rdata;

	logic                   emit;
	mwsa_pkg::kind_t        e_kind;
	mwsa_pkg::status_t      e_status;
	mwsa_pkg::addr_t        e_addr;
	mwsa_pkg::page_t        e_page;
	logic                   e_wake;

	assign free_vec = ~(pending_q | used_q);
	assign scan_idx = scan_q[IW-1:0];
	assign scan_end = (scan_q == CW'(NUM_SLOTS));
	assign fidx     = acc_q[mwsa_pkg::PAGE_SHIFT +: IW];
	assign oor      = (acc_q[mwsa_pkg::ADDR_W-1:mwsa_pkg::PAGE_SHIFT] >= HW'(NUM_SLOTS));
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req_known_op = req.operation inside
		{mwsa_pkg::OP_ALLOC, mwsa_pkg::OP_FLUSH, mwsa_pkg::OP_FREE};

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);

	// Lowest free slot.
	always_comb begin
		ff_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				ff_idx = IW'(i);
			end
		end
	end

	always_comb begin
		alu_op = mwsa_pkg::ALU_ADD;
		alu_a  = base_q;
		alu_b  = '0;
		case (state_q)
			S_ALLOC: begin
				alu_b = mwsa_pkg::ADDR_W'(ff_idx) << mwsa_pkg::PAGE_SHIFT;
			end
			S_ALLOC2: begin
				alu_a = acc_q;
				alu_b = mwsa_pkg::ADDR_W'(offset_q);
			end
			S_FLCHK: begin
				alu_b = mwsa_pkg::ADDR_W'(scan_idx) << mwsa_pkg::PAGE_SHIFT;
			end
			S_FREE: begin
				alu_op = mwsa_pkg::ALU_SUB;
				alu_a  = faddr_q;
				alu_b  = base_q;
			end
			default: begin
				alu_b = '0;
			end
		endcase
	end

	mwsa_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum)
	);

	assign ram_we = (state_q == S_ALLOC) && (free_cnt_q != '0);
	assign ram_re = (state_q == S_FLCHK) && !scan_end && pending_q[scan_idx];

	mwsa_ram #(
		.WIDTH (mwsa_pkg::PAGE_W),
		.DEPTH (NUM_SLOTS)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ff_idx),
		.wdata (page_q),
		.re    (ram_re),
		.raddr (scan_idx),
		.rdata (ram_rdata)
	);

	// Result to load into the output register this cycle, if any.
	always_comb begin
		emit     = 1'b0;
		e_kind   = mwsa_pkg::KIND_ALLOC;
		e_status = mwsa_pkg::ST_OK;
		e_addr   = '0;
		e_page   = '0;
		e_wake   = 1'b0;
		case (state_q)
			S_ALLOC: begin
				if (free_cnt_q == '0) begin
					emit     = out_free;
					e_status = wait_q ? mwsa_pkg::ST_FULL_WAIT : mwsa_pkg::ST_FULL_FATAL;
				end
			end
			S_ALLOC2: begin
				emit   = out_free;
				e_addr = alu_sum;
			end
			S_FLCHK: begin
				if (scan_end) begin
					emit   = out_free;
					e_kind = mwsa_pkg::KIND_DONE;
				end
			end
			S_FLEMIT: begin
				emit   = out_free;
				e_kind = mwsa_pkg::KIND_MAP;
				e_addr = acc_q;
				e_page = ram_rdata;
			end
			S_FREE2: begin
				emit   = out_free;
				e_kind = mwsa_pkg::KIND_FREE;
				e_addr = faddr_q;
				if (oor) begin
					e_status = mwsa_pkg::ST_OUT_RANGE;
				end else begin
					if (!used_q[fidx]) begin
						e_status = mwsa_pkg::ST_NOT_IN_USE;
					end
					e_wake = !free_vec[fidx] && (free_cnt_q == '0);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			pending_q   <= '0;
			used_q      <= '0;
			free_cnt_q  <= CW'(NUM_SLOTS);
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				base_q <= cfg.window_base;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						scan_q <= '0;
						case (req.operation)
							mwsa_pkg::OP_ALLOC: state_q <= S_ALLOC;
							mwsa_pkg::OP_FLUSH: state_q <= S_FLCHK;
							mwsa_pkg::OP_FREE:  state_q <= S_FREE;
							default:            state_q <= S_IDLE;
						endcase
					end
				end
				S_ALLOC: begin
					if (free_cnt_q != '0) begin
						pending_q[ff_idx] <= 1'b1;
						free_cnt_q        <= free_cnt_q - CW'(1);
						state_q           <= S_ALLOC2;
					end else if (emit) begin
						state_q <= S_IDLE;
					end
				end
				S_ALLOC2: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				S_FLCHK: begin
					if (scan_end) begin
						if (emit) begin
							state_q <= S_IDLE;
						end
					end else if (pending_q[scan_idx]) begin
						pending_q[scan_idx] <= 1'b0;
						used_q[scan_idx]    <= 1'b1;
						state_q             <= S_FLEMIT;
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				end
				S_FLEMIT: begin
					if (emit) begin
						scan_q  <= scan_q + CW'(1);
						state_q <= S_FLCHK;
					end
				end
				S_FREE: begin
					state_q <= S_FREE2;
				end
				S_FREE2: begin
					if (emit) begin
						if (!oor) begin
							if (!free_vec[fidx]) begin
								free_cnt_q <= free_cnt_q + CW'(1);
							end
							pending_q[fidx] <= 1'b0;
							used_q[fidx]    <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request fields, the adder's first result and the output payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			page_q   <= req.page_handle;
			offset_q <= req.page_offset;
			wait_q   <= req.may_wait;
			faddr_q  <= req.free_address;
		end
		if (state_q == S_ALLOC || state_q == S_FREE ||
		    (state_q == S_FLCHK && ram_re)) begin
			acc_q <= alu_sum;
		end
		if (emit) begin
			kind_q   <= e_kind;
			status_q <= e_status;
			addr_q   <= e_addr;
			mpage_q  <= e_page;
			wake_q   <= e_wake;
			last_q   <= (e_kind != mwsa_pkg::KIND_MAP);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.kind         = kind_q;
	assign rsp.status       = status_q;
	assign rsp.slot_address = addr_q;
	assign rsp.mapped_page  = mpage_q;
	assign rsp.wake_waiters = wake_q;
	assign rsp.last         = last_q;

	`MWSA_ASSERT_IMP(a_slot_excl, 1'b1, (pending_q & used_q) == '0, "slot pending and used")
	`MWSA_ASSERT_IMP(a_free_count, 1'b1, $countones(free_vec) == int'(free_cnt_q), "free count off")
	`MWSA_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready && req_known_op, state_q != S_IDLE, "idle after request")
endmodule
`default_nettype wire
